[hw/rtl/fxp_pkg.sv]
package fxp_pkg;

    // Fixed field widths of the link and key ports
    localparam int BYTE_W     = 8;
    localparam int KEY_ADDR_W = 7;
    localparam int SEQ_GRP_W  = 7;

    // Key-pad byte addresses the port can reach
    localparam int KEY_ADDR_SPAN = 2 ** KEY_ADDR_W;

    // Fraction bits of the reciprocal used to split a key address into row and lane
    localparam int RECIP_SH = 16;

    // Byte masks
    localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7F;

    // Item kinds
    typedef enum logic {
        MODE_LINK = 1'b0,
        MODE_KEY  = 1'b1
    } t_mode;

    // Key store access for one pipeline step
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [BYTE_W-1:0] wr_byte;
    } t_key_req;

endpackage

[hw/rtl/fxp_key_store.sv]
module fxp_key_store #(
    parameter int DATA_BYTES = 8,
    parameter int SEQ_BYTES  = 2,
    parameter int KEY_BLOCKS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fxp_pkg::t_key_req                    i_req,
    input  logic [fxp_pkg::KEY_ADDR_W-1:0]       i_wr_addr,
    input  logic [fxp_pkg::KEY_ADDR_W-1:0]       i_wr_row,
    input  logic [fxp_pkg::SEQ_GRP_W*SEQ_BYTES-1:0] i_rd_seq,
    output logic [fxp_pkg::BYTE_W*DATA_BYTES-1:0]  o_key
);
    import fxp_pkg::*;

    localparam int ROW_BITS   = BYTE_W * DATA_BYTES;
    localparam int PAD_LEN    = KEY_BLOCKS * DATA_BYTES;
    // Only rows reachable by the 7-bit key address need storage; the rest read as zero
    localparam int ADDR_ROWS  = (KEY_ADDR_SPAN + DATA_BYTES - 1) / DATA_BYTES;
    localparam int STORE_ROWS = (KEY_BLOCKS < ADDR_ROWS) ? KEY_BLOCKS : ADDR_ROWS;
    localparam int ROW_W      = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int LANE_W     = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

    logic [ROW_BITS-1:0]   r_key_mem [STORE_ROWS];
    logic [DATA_BYTES-1:0] r_key_vld [STORE_ROWS];
    logic [ROW_BITS-1:0]   r_rd_data;
    logic [DATA_BYTES-1:0] r_rd_mask;

    logic                  wr_ok;
    logic [KEY_ADDR_W-1:0] wr_lane_full;
    logic [ROW_W-1:0]      wr_row_idx;
    logic [LANE_W-1:0]     wr_lane_idx;
    logic                  rd_in;
    logic [ROW_W-1:0]      rd_idx;

    // Write address: lane is what is left after the row
    always_comb begin
        wr_ok        = 32'(i_wr_addr) < PAD_LEN;
        wr_lane_full = KEY_ADDR_W'(i_wr_addr - KEY_ADDR_W'(32'(i_wr_row) * DATA_BYTES));
        wr_row_idx   = ROW_W'(i_wr_row);
        wr_lane_idx  = LANE_W'(wr_lane_full);
        rd_in        = 32'(i_rd_seq) < STORE_ROWS;
        rd_idx       = rd_in ? ROW_W'(i_rd_seq) : '0;
    end

    // Row memory with byte-lane writes and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && wr_ok) begin
            r_key_mem[wr_row_idx][8*wr_lane_idx +: 8] <= i_req.wr_byte;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_key_mem[rd_idx];
        end
    end

    // Per-byte written flags; unwritten bytes read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < STORE_ROWS; r++) begin
                r_key_vld[r] <= '0;
            end
            r_rd_mask <= '0;
        end else begin
            if (i_req.wr_en && wr_ok) begin
                r_key_vld[wr_row_idx][wr_lane_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_mask <= rd_in ? r_key_vld[rd_idx] : '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DATA_BYTES; i++) begin
            o_key[i*BYTE_W +: BYTE_W] = r_rd_data[i*BYTE_W +: BYTE_W] & {BYTE_W{r_rd_mask[i]}};
        end
    end

endmodule

[hw/rtl/fxp_frame_check.sv]
module fxp_frame_check #(
    parameter int DATA_BYTES = 8,
    parameter int SEQ_BYTES  = 2,
    parameter int KEY_BLOCKS = 10
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_adv,
    input  logic                                           i_item_vld,
    input  logic                                           i_mode,
    input  logic [fxp_pkg::BYTE_W-1:0]                     i_byte,
    output logic                                           o_hit,
    output logic [fxp_pkg::SEQ_GRP_W*SEQ_BYTES-1:0]        o_seq,
    output logic                                           o_s2_vld,
    output logic [DATA_BYTES+SEQ_BYTES-1:0][fxp_pkg::BYTE_W-1:0] o_s2_win
);
    import fxp_pkg::*;

    localparam int WIN_LEN = DATA_BYTES + SEQ_BYTES;
    localparam int SEQ_W   = SEQ_GRP_W * SEQ_BYTES;

    logic [WIN_LEN-1:0][BYTE_W-1:0] r_window;
    logic [WIN_LEN-1:0][BYTE_W-1:0] r_s2_win;
    logic [SEQ_W-1:0]               r_last_seq;
    logic                           r_seen;
    logic                           r_s2_vld;

    logic [WIN_LEN-1:0][BYTE_W-1:0] n_window;
    logic                           link_item;
    logic                           marks_ok;
    logic                           seq_newer;
    logic                           seq_in_pad;

    // Shifted window, frame marks and sequence number
    always_comb begin
        n_window[0] = i_byte;
        for (int i = 1; i < WIN_LEN; i++) begin
            n_window[i] = r_window[i-1];
        end
        marks_ok = 1'b1;
        for (int i = 0; i < WIN_LEN; i++) begin
            if (i < DATA_BYTES) begin
                if (n_window[i][BYTE_W-1]) marks_ok = 1'b0;
            end else begin
                if (!n_window[i][BYTE_W-1]) marks_ok = 1'b0;
            end
        end
        for (int i = 0; i < SEQ_BYTES; i++) begin
            o_seq[i*SEQ_GRP_W +: SEQ_GRP_W] = n_window[WIN_LEN-1-i][SEQ_GRP_W-1:0];
        end
        link_item  = i_item_vld && (t_mode'(i_mode) == MODE_LINK);
        seq_newer  = !r_seen || (o_seq > r_last_seq);
        seq_in_pad = 32'(o_seq) < KEY_BLOCKS;
        o_hit      = link_item && marks_ok && seq_newer && seq_in_pad;
    end

    // Window and sequence tracking; the window keeps raw bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_last_seq <= '0;
            r_seen     <= 1'b0;
            r_s2_vld   <= 1'b0;
        end else if (i_adv) begin
            if (link_item) begin
                r_window <= n_window;
            end
            if (o_hit) begin
                r_seen     <= 1'b1;
                r_last_seq <= o_seq;
            end
            r_s2_vld <= o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && o_hit) begin
            r_s2_win <= n_window;
        end
    end

    assign o_s2_vld = r_s2_vld;
    assign o_s2_win = r_s2_win;

`ifndef ASSERT_OFF
    // An accepted frame becomes the new reference number
    a_seq_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_hit |=> r_seen && (r_last_seq == $past(o_seq)))
        else $error("sequence reference not updated after frame");

    // A held frame carries the frame marks
    a_held_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> !r_s2_win[0][BYTE_W-1] && r_s2_win[DATA_BYTES][BYTE_W-1])
        else $error("held frame without frame marks");
`endif

endmodule

[hw/rtl/fxp_out_buffer.sv]
module fxp_out_buffer #(
    parameter int DATA_BYTES = 8,
    parameter int SEQ_BYTES  = 2
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_load,
    input  logic [DATA_BYTES+SEQ_BYTES-1:0][fxp_pkg::BYTE_W-1:0] i_win,
    input  logic [fxp_pkg::BYTE_W*DATA_BYTES-1:0]                i_key,
    input  logic                                                 i_ready,
    output logic                                                 o_valid,
    output logic [fxp_pkg::BYTE_W-1:0]                           o_byte,
    output logic                                                 o_last,
    output logic                                                 o_empty
);
    import fxp_pkg::*;

    localparam int WIN_LEN = DATA_BYTES + SEQ_BYTES;
    localparam int CNT_W   = $clog2(WIN_LEN + 1);

    logic [WIN_LEN-1:0][BYTE_W-1:0] r_obuf;
    logic [CNT_W-1:0]               r_ocnt;
    logic                           xfer;

    assign o_valid = r_ocnt != '0;
    assign o_empty = r_ocnt == '0;
    assign o_last  = r_ocnt == CNT_W'(1);
    assign o_byte  = r_obuf[0];
    assign xfer    = o_valid && i_ready;

    // Remaining byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
        end else if (i_load) begin
            r_ocnt <= CNT_W'(WIN_LEN);
        end else if (xfer) begin
            r_ocnt <= r_ocnt - CNT_W'(1);
        end
    end

    // Decrypt on load, then shift out slot 0 first
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                if (i < DATA_BYTES) begin
                    r_obuf[i] <= (i_win[i] ^ i_key[i*BYTE_W +: BYTE_W]) & LOW7_MASK;
                end else begin
                    r_obuf[i] <= i_win[i];
                end
            end
        end else if (xfer) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_obuf[i] <= r_obuf[i+1];
            end
        end
    end

`ifndef ASSERT_OFF
    // A frame only loads into an empty buffer or one sending its last byte
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_ocnt == '0) || (o_last && i_ready))
        else $error("frame loaded over pending bytes");

    // After the final byte transfer with no new frame the buffer is drained
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && i_ready && !i_load |=> !o_valid)
        else $error("bytes remain after last transfer");
`endif

endmodule

[hw/rtl/framed_xor_pad_decrypter_core.sv]
// Framed XOR pad decrypter. Link bytes (mode 0) slide through a window of
// DATA_BYTES + SEQ_BYTES slots; when the window forms a frame with a sequence
// number newer than the last one and inside the key pad, the data bytes are
// XORed with that number's pad block, MSBs cleared, and the whole window is
// sent out slot 0 first, the final byte marked last. Mode-1 items write one
// pad byte. One item is taken every cycle unless input stalls; a frame's
// closing byte passes the input register and held-frame register into the
// output buffer, whose bytes then leave one per cycle while the receiver is
// ready; it takes the next frame on the transfer of its last byte. Input
// stalls only while a detected frame waits for a buffer that the receiver is
// slow to drain; with the receiver always ready, frames one window length apart,
// the closest the frame marks allow, pass without a stall. The pad store needs
// no clearing pass: per-byte written flags make it read zero after reset.
module framed_xor_pad_decrypter_core #(
    parameter int DATA_BYTES = 8,
    parameter int SEQ_BYTES  = 2,
    parameter int KEY_BLOCKS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic [fxp_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic [fxp_pkg::KEY_ADDR_W-1:0]    i_key_address,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fxp_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                              o_last_byte
);
    import fxp_pkg::*;

    localparam int WIN_LEN   = DATA_BYTES + SEQ_BYTES;
    localparam int SEQ_W     = SEQ_GRP_W * SEQ_BYTES;
    localparam int RECIP     = (2 ** RECIP_SH + DATA_BYTES - 1) / DATA_BYTES;
    localparam int PROD_W    = KEY_ADDR_W + RECIP_SH + 1;

    // Input register
    logic                  r_s1_vld;
    logic                  r_s1_mode;
    logic [BYTE_W-1:0]     r_s1_byte;
    logic [KEY_ADDR_W-1:0] r_s1_addr;
    logic [KEY_ADDR_W-1:0] r_s1_row;

    logic                           accept;
    logic                           s1_adv;
    logic                           s2_busy;
    logic [PROD_W-1:0]              addr_prod;
    logic                           hit;
    logic [SEQ_W-1:0]               seq;
    logic                           s2_vld;
    logic [WIN_LEN-1:0][BYTE_W-1:0] s2_win;
    logic [BYTE_W*DATA_BYTES-1:0]   key_row;
    logic                           obuf_empty;
    logic                           obuf_free;
    t_key_req                       key_req;

    // Pipeline flow: a detected frame holds until the output buffer is empty
    // or sends its last byte in this cycle
    assign obuf_free = obuf_empty || (o_valid && o_last_byte && i_ready);
    assign s2_busy   = s2_vld && !obuf_free;
    assign s1_adv    = !s2_busy;
    assign o_ready   = !r_s1_vld || s1_adv;
    assign accept    = i_valid && o_ready;

    // Key address row by reciprocal multiply
    assign addr_prod = PROD_W'(i_key_address) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode <= i_mode;
            r_s1_byte <= i_byte_value;
            r_s1_addr <= i_key_address;
            r_s1_row  <= addr_prod[RECIP_SH +: KEY_ADDR_W];
        end
    end

    // Key store access for the item in the input register
    always_comb begin
        key_req.wr_en   = s1_adv && r_s1_vld && (t_mode'(r_s1_mode) == MODE_KEY);
        key_req.rd_en   = s1_adv;
        key_req.wr_byte = r_s1_byte;
    end

    fxp_frame_check #(
        .DATA_BYTES (DATA_BYTES),
        .SEQ_BYTES  (SEQ_BYTES),
        .KEY_BLOCKS (KEY_BLOCKS)
    ) u_frame_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (s1_adv),
        .i_item_vld (r_s1_vld),
        .i_mode     (r_s1_mode),
        .i_byte     (r_s1_byte),
        .o_hit      (hit),
        .o_seq      (seq),
        .o_s2_vld   (s2_vld),
        .o_s2_win   (s2_win)
    );

    fxp_key_store #(
        .DATA_BYTES (DATA_BYTES),
        .SEQ_BYTES  (SEQ_BYTES),
        .KEY_BLOCKS (KEY_BLOCKS)
    ) u_key_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (key_req),
        .i_wr_addr (r_s1_addr),
        .i_wr_row  (r_s1_row),
        .i_rd_seq  (seq),
        .o_key     (key_row)
    );

    fxp_out_buffer #(
        .DATA_BYTES (DATA_BYTES),
        .SEQ_BYTES  (SEQ_BYTES)
    ) u_out_buffer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s2_vld && obuf_free),
        .i_win   (s2_win),
        .i_key   (key_row),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_byte  (o_out_byte),
        .o_last  (o_last_byte),
        .o_empty (obuf_empty)
    );

    // hit is only consumed through the frame check's held frame
    logic unused_hit;
    assign unused_hit = hit;

endmodule
